FILE: sv/wple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wple_pkg;

    localparam int MAX_PIXELS_DEF = 256;

    localparam int PIX_W    = 8;
    localparam int COLOR_W  = 8;
    localparam int WORD_W   = 3 * COLOR_W;
    localparam int TIME_W   = 16;
    localparam int BITPOS_W = 5;
    localparam int OP_W     = 2;
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [BITPOS_W-1:0] BIT_MSB = BITPOS_W'(WORD_W - 1);

    localparam logic [PIX_W-1:0]   NUM_LEDS_RST  = 8'd0;
    localparam logic [7:0]         ONE_HIGH_RST  = 8'd4;
    localparam logic [7:0]         ONE_LOW_RST   = 8'd6;
    localparam logic [7:0]         ZERO_HIGH_RST = 8'd2;
    localparam logic [7:0]         ZERO_LOW_RST  = 8'd13;
    localparam logic [TIME_W-1:0]  LATCH_RST     = 16'd960;

    typedef enum logic [OP_W-1:0] {
        OP_TICK,
        OP_WRITE,
        OP_CLEAR,
        OP_SHOW
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } t_phase;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_LEDS,
        REG_ONE_HIGH,
        REG_ONE_LOW,
        REG_ZERO_HIGH,
        REG_ZERO_LOW,
        REG_LATCH
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]  num_leds;
        logic [7:0]        one_high_ticks;
        logic [7:0]        one_low_ticks;
        logic [7:0]        zero_high_ticks;
        logic [7:0]        zero_low_ticks;
        logic [TIME_W-1:0] latch_ticks;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [PIX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_cmd;

    typedef struct packed {
        logic line;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [PIX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              clr;
        logic              rd_en;
        logic [PIX_W-1:0]  rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              pend;
        logic [WORD_W-1:0] data;
    } t_mem_rsp;

    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        at_least_one = (v == '0) ? TIME_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ws2811_pixel_line_encoder.sv
// Channel   Direction  Payload
// s_axis    in         tuser: op; tdata: pixel_index, red, green, blue
// m_axis    out        tdata: line, busy_res, accepted; tlast: frame_done
// APB       in/out     six timing and length registers, byte address 4*i
//
// Each transaction on s_axis is one line tick; a new one
// is taken every cycle while the output register is free or being drained.
// Its result appears in the output register in the cycle after it is taken.
// The pixel buffer has one write port and one registered read port; the next
// pixel is fetched right after each load, so reads never delay a tick.
// Reset and a clear command empty the buffer at once through per-entry valid
// bits, with no sweep; s_axis stalls only while m_axis holds a result.
`timescale 1ns / 1ps
`default_nettype none

module ws2811_pixel_line_encoder
    import wple_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: pixel_index[7:0], red[15:8], green[23:16], blue[31:24].
    input  wire logic [31:0]       s_axis_tdata,
    // Fields from bit 0: op[1:0].
    input  wire logic [OP_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // Fields from bit 0: line[0], busy_res[1], accepted[2], zero fill[7:3].
    output logic [7:0]             m_axis_tdata,
    output logic                   m_axis_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg     w_cfg;
    t_cmd     w_cmd;
    t_mem_req w_req;
    t_mem_rsp w_rsp;
    t_result  w_result;
    t_result  r_out;
    logic     r_out_valid;
    logic     w_take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    assign w_cmd.op          = t_op'(s_axis_tuser);
    assign w_cmd.pixel_index = s_axis_tdata[7:0];
    assign w_cmd.red         = s_axis_tdata[15:8];
    assign w_cmd.green       = s_axis_tdata[23:16];
    assign w_cmd.blue        = s_axis_tdata[31:24];

    wple_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    wple_pixel_mem #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    wple_seq #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_take),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_rsp    (w_rsp),
        .o_req    (w_req),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.accepted, r_out.busy_res, r_out.line};
    assign m_axis_tlast  = r_out.frame_done;

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> m_axis_tvalid)
        else $error("Accepted transaction produced no result.");

    a_line_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("Line driven high outside a frame.");

    a_done_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("Frame end reported outside the latch period.");

endmodule

`default_nettype wire

FILE: sv/wple_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wple_regs
    import wple_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [CFG_AW-1:0] i_paddr,
    input  wire logic [CFG_DW-1:0] i_pwdata,
    output logic      [CFG_DW-1:0] o_prdata,
    output logic                   o_pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[CFG_AW-1:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_leds        <= NUM_LEDS_RST;
            r_cfg.one_high_ticks  <= ONE_HIGH_RST;
            r_cfg.one_low_ticks   <= ONE_LOW_RST;
            r_cfg.zero_high_ticks <= ZERO_HIGH_RST;
            r_cfg.zero_low_ticks  <= ZERO_LOW_RST;
            r_cfg.latch_ticks     <= LATCH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_NUM_LEDS:  r_cfg.num_leds        <= i_pwdata[PIX_W-1:0];
                REG_ONE_HIGH:  r_cfg.one_high_ticks  <= i_pwdata[7:0];
                REG_ONE_LOW:   r_cfg.one_low_ticks   <= i_pwdata[7:0];
                REG_ZERO_HIGH: r_cfg.zero_high_ticks <= i_pwdata[7:0];
                REG_ZERO_LOW:  r_cfg.zero_low_ticks  <= i_pwdata[7:0];
                REG_LATCH:     r_cfg.latch_ticks     <= i_pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NUM_LEDS:  o_prdata = CFG_DW'(r_cfg.num_leds);
            REG_ONE_HIGH:  o_prdata = CFG_DW'(r_cfg.one_high_ticks);
            REG_ONE_LOW:   o_prdata = CFG_DW'(r_cfg.one_low_ticks);
            REG_ZERO_HIGH: o_prdata = CFG_DW'(r_cfg.zero_high_ticks);
            REG_ZERO_LOW:  o_prdata = CFG_DW'(r_cfg.zero_low_ticks);
            REG_LATCH:     o_prdata = CFG_DW'(r_cfg.latch_ticks);
            default:       o_prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/wple_pixel_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module wple_pixel_mem
    import wple_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_mem_req  i_req,
    output t_mem_rsp  o_rsp
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [WORD_W-1:0]     r_mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_valid;
    logic [WORD_W-1:0]     r_rd_word;
    logic                  r_rd_hit;
    logic                  r_rd_pend;

    // Entries not written since reset or the last clear read as zero.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        r_rd_word <= r_mem[i_req.rd_addr[AW-1:0]];
        r_rd_hit  <= r_valid[i_req.rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_req.rd_en;
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign o_rsp.pend = r_rd_pend;
    assign o_rsp.data = r_rd_hit ? r_rd_word : '0;

endmodule

`default_nettype wire

FILE: sv/wple_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module wple_seq
    import wple_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_tick,
    input  t_cmd      i_cmd,
    input  t_cfg      i_cfg,
    input  t_mem_rsp  i_rsp,
    output t_mem_req  o_req,
    output t_result   o_result
);

    localparam logic [PIX_W:0] PixLimit = (PIX_W + 1)'(MAX_PIXELS);

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_time, n_time;
    logic [BITPOS_W-1:0] r_bit, n_bit;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic [WORD_W-1:0] r_shift, n_shift;
    logic [WORD_W-1:0] r_next_word, n_next_word;

    logic [WORD_W-1:0] w_nw;
    logic              w_fetch;
    logic [PIX_W:0]    w_fetch_addr;
    t_phase            w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bit       <= '0;
            r_pix       <= '0;
            r_shift     <= '0;
            r_next_word <= '0;
        end else begin
            r_phase     <= n_phase;
            r_time      <= n_time;
            r_bit       <= n_bit;
            r_pix       <= n_pix;
            r_shift     <= n_shift;
            r_next_word <= n_next_word;
        end
    end

    // r_next_word, or the buffer's read data while a read is pending, holds the
    // pixel that the next load takes; a buffer read issued with each load refills it.
    always_comb begin
        n_phase      = r_phase;
        n_time       = r_time;
        n_bit        = r_bit;
        n_pix        = r_pix;
        n_shift      = r_shift;
        w_nw         = i_rsp.pend ? i_rsp.data : r_next_word;
        n_next_word  = w_nw;
        w_fetch      = 1'b0;
        w_fetch_addr = '0;
        w_cur        = r_phase;
        o_req        = '0;
        o_result     = '{line: 1'b0, busy_res: 1'b0, accepted: 1'b1, frame_done: 1'b0};

        if (i_tick) begin
            if (i_cmd.op != OP_TICK) begin
                if (r_phase != PH_IDLE) begin
                    o_result.accepted = 1'b0;
                end else begin
                    case (i_cmd.op)
                        OP_WRITE: begin
                            if ({1'b0, i_cmd.pixel_index} < PixLimit) begin
                                o_req.wr_en   = 1'b1;
                                o_req.wr_addr = i_cmd.pixel_index;
                                o_req.wr_data = {i_cmd.green, i_cmd.red, i_cmd.blue};
                                if (i_cmd.pixel_index == '0) begin
                                    n_next_word = {i_cmd.green, i_cmd.red, i_cmd.blue};
                                end
                            end else begin
                                o_result.accepted = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            o_req.clr   = 1'b1;
                            n_next_word = '0;
                        end
                        OP_SHOW: begin
                            n_pix = '0;
                            if (n_pix < i_cfg.num_leds) begin
                                n_shift      = w_nw;
                                n_bit        = BIT_MSB;
                                n_phase      = PH_HIGH;
                                n_time       = at_least_one(TIME_W'(n_shift[n_bit] ?
                                               i_cfg.one_high_ticks : i_cfg.zero_high_ticks));
                                w_fetch      = 1'b1;
                                w_fetch_addr = {1'b0, n_pix} + (PIX_W + 1)'(1);
                            end else begin
                                n_phase      = PH_LATCH;
                                n_time       = at_least_one(i_cfg.latch_ticks);
                                w_fetch      = 1'b1;
                                w_fetch_addr = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            w_cur = n_phase;
            if (w_cur != PH_IDLE) begin
                o_result.busy_res = 1'b1;
                o_result.line     = (w_cur == PH_HIGH);
                n_time            = n_time - TIME_W'(1);
                if (n_time == '0) begin
                    case (w_cur)
                        PH_HIGH: begin
                            n_phase = PH_LOW;
                            n_time  = at_least_one(TIME_W'(n_shift[n_bit] ?
                                      i_cfg.one_low_ticks : i_cfg.zero_low_ticks));
                        end
                        PH_LOW: begin
                            if (n_bit != '0) begin
                                n_bit   = n_bit - BITPOS_W'(1);
                                n_phase = PH_HIGH;
                                n_time  = at_least_one(TIME_W'(n_shift[n_bit] ?
                                          i_cfg.one_high_ticks : i_cfg.zero_high_ticks));
                            end else begin
                                n_pix = n_pix + PIX_W'(1);
                                if (n_pix != '0 && n_pix < i_cfg.num_leds) begin
                                    n_shift      = ({1'b0, n_pix} < PixLimit) ? w_nw : '0;
                                    n_bit        = BIT_MSB;
                                    n_phase      = PH_HIGH;
                                    n_time       = at_least_one(TIME_W'(n_shift[n_bit] ?
                                                   i_cfg.one_high_ticks :
                                                   i_cfg.zero_high_ticks));
                                    w_fetch      = 1'b1;
                                    w_fetch_addr = {1'b0, n_pix} + (PIX_W + 1)'(1);
                                end else begin
                                    n_phase      = PH_LATCH;
                                    n_time       = at_least_one(i_cfg.latch_ticks);
                                    w_fetch      = 1'b1;
                                    w_fetch_addr = '0;
                                end
                            end
                        end
                        PH_LATCH: begin
                            n_phase             = PH_IDLE;
                            o_result.frame_done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end

        if (w_fetch) begin
            if (w_fetch_addr < PixLimit) begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = w_fetch_addr[PIX_W-1:0];
            end else begin
                n_next_word = '0;
            end
        end
    end

endmodule

`default_nettype wire
